FILE: rtl/lpwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpwm_pkg: shared types and constants of the six-channel LED driver
// Configuration record, register indexes, counter limits and link codes.
// ----------------------------------------------------------------------------
package lpwm_pkg;

	localparam int NUM_PWM_CH = 5;
	localparam int NUM_DUTY   = 6;
	localparam int DUTY_W     = 7;
	localparam int IDX_W      = 3;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_PWM_MASK   = 3'd0;
	localparam logic [IDX_W-1:0] REG_BLINK_MASK = 3'd1;
	localparam logic [IDX_W-1:0] REG_DUTY_ONE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DUTY_TWO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DUTY_THREE = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_FOUR  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DUTY_FIVE  = 3'd6;
	localparam logic [IDX_W-1:0] REG_DUTY_SIX   = 3'd7;

	// link status codes
	localparam logic [2:0] LINK_SLOW      = 3'd1;
	localparam logic [2:0] LINK_VERY_SLOW = 3'd2;
	localparam logic [2:0] LINK_ON_A      = 3'd4;
	localparam logic [2:0] LINK_ON_B      = 3'd5;

	// counter limits
	localparam logic [6:0]  PWM_PHASE_MAX  = 7'd99;
	localparam logic [6:0]  LEVEL_FULL     = 7'd100;
	localparam logic [13:0] BLINK_MAX      = 14'd10000;
	localparam logic [13:0] BLINK_HALF     = 14'd5000;
	localparam logic [14:0] LINK_SLOW_PER  = 15'd5000;
	localparam logic [14:0] LINK_SLOW_ON   = 15'd2500;
	localparam logic [14:0] LINK_VSLOW_PER = 15'd30000;
	localparam logic [14:0] LINK_VSLOW_ON  = 15'd15000;

	// reciprocal of 100 with a 19-bit shift, exact for values up to 10000
	localparam logic [12:0] RECIP_100      = 13'd5243;
	localparam int          RECIP_SHIFT    = 19;

	localparam logic [2:0]  CHASE_LAST     = 3'd4;

	typedef struct packed {
		logic [NUM_PWM_CH-1:0]              pwm_mask;
		logic [NUM_PWM_CH-1:0]              blink_mask;
		logic [NUM_DUTY-1:0][DUTY_W-1:0]    duty;
	} lpwm_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/lpwm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpwm_cfg: configuration registers
// Holds the mode masks and the six duty values written over the config port.
// ----------------------------------------------------------------------------
module lpwm_cfg
	import lpwm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_index,
	input  wire logic [DUTY_W-1:0] wr_data,
	output lpwm_cfg_t              cfg
);

	lpwm_cfg_t cfg_q;

	// write one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PWM_MASK:   cfg_q.pwm_mask   <= wr_data[NUM_PWM_CH-1:0];
				REG_BLINK_MASK: cfg_q.blink_mask <= wr_data[NUM_PWM_CH-1:0];
				REG_DUTY_ONE:   cfg_q.duty[0]    <= wr_data;
				REG_DUTY_TWO:   cfg_q.duty[1]    <= wr_data;
				REG_DUTY_THREE: cfg_q.duty[2]    <= wr_data;
				REG_DUTY_FOUR:  cfg_q.duty[3]    <= wr_data;
				REG_DUTY_FIVE:  cfg_q.duty[4]    <= wr_data;
				REG_DUTY_SIX:   cfg_q.duty[5]    <= wr_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/lpwm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpwm_core: tick engine
// Advances the phase counters per tick, the chase step at the blink midpoint,
// and latches six pin levels; the pin register is also the result register.
// ----------------------------------------------------------------------------
module lpwm_core
	import lpwm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lpwm_cfg_t  cfg,
	input  wire logic       step,
	input  wire logic [2:0] link_status,
	input  wire logic       home_mode,
	input  wire logic       chase_mode,
	output logic [5:0]      pins
);

	logic [6:0]  pwm_phase_q,   pwm_phase_n;
	logic [13:0] blink_phase_q, blink_phase_n;
	logic [14:0] link_phase_q,  link_phase_n;
	logic        dir_q,         dir_n;
	logic [2:0]  chase_q,       chase_n;
	logic [5:0]  pins_q,        pins_n;

	logic [14:0] link_on_len;
	logic [26:0] quot_prod;
	logic [6:0]  breathe_v;
	logic        breathe_en;
	logic [6:0]  level;

	// scale the blink counter down by 100
	assign quot_prod  = {13'd0, blink_phase_n} * {14'd0, RECIP_100};
	assign breathe_v  = quot_prod[RECIP_SHIFT+6:RECIP_SHIFT];
	assign breathe_en = cfg.pwm_mask[0] && home_mode;

	// next state of one tick
	always_comb begin
		pwm_phase_n   = (pwm_phase_q < PWM_PHASE_MAX) ? pwm_phase_q + 7'd1 : 7'd1;
		blink_phase_n = (blink_phase_q < BLINK_MAX) ? blink_phase_q + 14'd1 : 14'd0;

		// advance and apply the chase step
		chase_n = chase_q;
		pins_n  = pins_q;
		if (chase_mode) begin
			if (blink_phase_n == BLINK_HALF) begin
				chase_n = (chase_q >= CHASE_LAST) ? 3'd1 : chase_q + 3'd1;
			end
			case (chase_n)
				3'd1:    pins_n[0]   = 1'b1;
				3'd2:    pins_n[1:0] = 2'b11;
				3'd3:    pins_n[2:0] = 3'b111;
				3'd4:    pins_n[2:0] = 3'b000;
				default: pins_n      = pins_n;
			endcase
		end

		// link blink counter
		case (link_status)
			LINK_SLOW: begin
				link_on_len  = LINK_SLOW_ON;
				link_phase_n = (link_phase_q < LINK_SLOW_PER) ? link_phase_q + 15'd1 : 15'd0;
			end
			LINK_VERY_SLOW: begin
				link_on_len  = LINK_VSLOW_ON;
				link_phase_n = (link_phase_q < LINK_VSLOW_PER) ? link_phase_q + 15'd1 : 15'd0;
			end
			LINK_ON_A, LINK_ON_B: begin
				link_on_len  = 15'd1;
				link_phase_n = 15'd0;
			end
			default: begin
				link_on_len  = 15'd0;
				link_phase_n = 15'd1;
			end
		endcase

		// breathing level of channel one
		dir_n = dir_q ^ (breathe_en && (breathe_v > PWM_PHASE_MAX));
		if (breathe_en) begin
			level = dir_n ? breathe_v : LEVEL_FULL - breathe_v;
		end else begin
			level = cfg.duty[0];
		end

		// PWM wins over blink
		for (int ch = 0; ch < NUM_PWM_CH; ch++) begin
			if (cfg.pwm_mask[ch]) begin
				pins_n[ch] = ((ch == 0) ? level : cfg.duty[ch]) >= pwm_phase_n;
			end else if (cfg.blink_mask[ch]) begin
				pins_n[ch] = blink_phase_n < BLINK_HALF;
			end
		end
		pins_n[5] = link_phase_n < link_on_len;

		// drop idle channels unless the chase holds them
		if (!chase_mode) begin
			pins_n[NUM_PWM_CH-1:0] = pins_n[NUM_PWM_CH-1:0] & (cfg.pwm_mask | cfg.blink_mask);
		end
	end

	// update all state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_phase_q   <= 7'd1;
			blink_phase_q <= '0;
			link_phase_q  <= '0;
			dir_q         <= 1'b0;
			chase_q       <= '0;
			pins_q        <= '0;
		end else if (step) begin
			pwm_phase_q   <= pwm_phase_n;
			blink_phase_q <= blink_phase_n;
			link_phase_q  <= link_phase_n;
			dir_q         <= dir_n;
			chase_q       <= chase_n;
			pins_q        <= pins_n;
		end
	end

	assign pins = pins_q;

	// no tick, no state change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pins_q) && $stable(blink_phase_q) && $stable(chase_q))
		else $error("state changed without a tick");

	// channels in neither mode go low when chase is off
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		step && !chase_mode |=>
		(pins_q[NUM_PWM_CH-1:0] & ~$past(cfg.pwm_mask | cfg.blink_mask)) == '0)
		else $error("idle channel left high");

	// link off codes turn LED six off
	a_link_off: assert property (@(posedge clk) disable iff (!arst_n)
		step && link_status != LINK_SLOW && link_status != LINK_VERY_SLOW &&
		link_status != LINK_ON_A && link_status != LINK_ON_B
		|=> !pins_q[5] && link_phase_q == 15'd1)
		else $error("LED six on with link off");

	// chase step only moves on the blink midpoint
	a_chase: assert property (@(posedge clk) disable iff (!arst_n)
		step && (!chase_mode || blink_phase_n != BLINK_HALF) |=> $stable(chase_q))
		else $error("chase step moved off the midpoint");

endmodule
`default_nettype wire

FILE: rtl/six_channel_led_pwm_blink_driver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// six_channel_led_pwm_blink_driver: six-channel LED PWM and blink driver
// Each input transfer is one timebase tick; each tick returns the six pin
// levels latched for the following tick.
//
// Channels: s_* carries ticks in (tdata: link_status, home_mode, chase_mode),
// m_* returns one result per tick (tdata: led_levels), and cfg_* writes the
// mode masks and duties (index 0 PWM mask, 1 blink mask, 2..7 duties).
// cfg_ready is always high; write configuration only while no tick is in
// flight.
// Pipeline: an accepted tick is registered in the input stage, and its levels
// are then registered in the pin register, which drives m_tdata; a stalled
// result holds the tick in the input stage.
// Throughput: one tick per cycle while m_tready is high; the pin register
// doubles as output register; the engine advances whenever it is empty or taken.
// Reset: all channels off, PWM phase at 1, other counters and masks cleared.
// Stall: while m_tready is low the result holds, one more tick is taken into
// the input stage, and s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module six_channel_led_pwm_blink_driver
	import lpwm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// tick in: [2:0] link_status, [3] home_mode, [4] chase_mode, [7:5] zero
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,
	// result out: [5:0] led_levels, [7:6] zero
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,
	// configuration write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DUTY_W-1:0] cfg_data
);

	lpwm_cfg_t  cfg;
	logic       valid_s1;
	logic [2:0] status_s1;
	logic       home_s1;
	logic       chase_s1;
	logic       out_valid_q;
	logic       advance;
	logic [5:0] pins;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	lpwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// capture the tick payload on transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			status_s1 <= s_tdata[2:0];
			home_s1   <= s_tdata[3];
			chase_s1  <= s_tdata[4];
		end
	end

	lpwm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (advance),
		.link_status (status_s1),
		.home_mode   (home_s1),
		.chase_mode  (chase_s1),
		.pins        (pins)
	);

	// result valid: set on each tick, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, pins};

	// a full input stage behind a stalled result blocks new ticks
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("tick accepted while both stages are full");

	// every tick yields a pending result on the next edge
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("tick without result");

	// stalled result holds its levels
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(pins))
		else $error("stalled result changed");

endmodule
`default_nettype wire
